// File: design/supply_rail_monitor_regs_assert.svh
// ----------------------------------------------------------------------------
// Supply rail monitor assertion macros
// Shorthand for clocked properties checked against aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_RAIL_MONITOR_REGS_ASSERT_SVH
`define SUPPLY_RAIL_MONITOR_REGS_ASSERT_SVH

// same-cycle implication
`define SRM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("supply rail monitor: property violated");

// next-cycle implication
`define SRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("supply rail monitor: property violated");

`endif

// File: design/srm_pkg.sv
// ----------------------------------------------------------------------------
// Supply rail monitor package
// Shared constants, request codes and the result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

    localparam int unsigned NUM_RAILS_DEF = 5;

    // control entry bits
    localparam int unsigned BIT_EN   = 0;
    localparam int unsigned BIT_PG   = 1;
    localparam int unsigned BIT_LAST = 2;

    localparam logic [7:0] BYTE_BAD = 8'h80;

    // request codes carried on s_tuser
    localparam logic [1:0] REQ_POLL  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // configuration registers
    localparam logic [0:0] REG_KEEP_ALIVE = 1'b0;
    localparam logic [2:0] KEEP_ALIVE_RESET = 3'd4;

    // entry index of the rail that comes out of reset enabled (rail 4)
    localparam logic [2:0] RESET_EN_IDX = 3'd3;

    typedef struct packed {
        logic       fault_led;
        logic       rail_led;
        logic       keep_alive_hold;
        logic       turn_off;
        logic       turn_on;
        logic [2:0] polled_rail;
        logic [7:0] read_byte;
    } result_t;

    function automatic logic [2:0] rail_reset(input logic [2:0] idx);
        logic [2:0] val;
        val = '0;
        if (idx == RESET_EN_IDX) begin
            val[BIT_EN] = 1'b1;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// File: design/supply_rail_monitor_regs.sv
// ----------------------------------------------------------------------------
// Supply rail monitor register file
// Control entries for the supply rails, bus access and round-robin polling.
// ----------------------------------------------------------------------------
//
//  channel | direction | contents
//  --------+-----------+------------------------------------------------------
//  s_      | in        | one request: poll tick, bus read or bus write
//  m_      | out       | one result item per request
//  APB     | in/out    | keep_alive_rail register at byte address 0
//
//  For each item, the accept edge issues the read of the rail entry
//  memory, the next edge modifies and writes it back and loads the
//  output register. A new item is taken only in the idle state, once the
//  output register is free or is being emptied, so the block cannot take
//  a new item before it is through with the last one.
//  aresetn is synchronous; it clears the entry valid bits (unwritten entries
//  read as their reset value) and the fault flag, returns the poll pointer to
//  rail 1 and the keep-alive register to rail 4.
//  A stall on m_tready holds the result and blocks new items.
// ----------------------------------------------------------------------------
`default_nettype none

module supply_rail_monitor_regs #(
    parameter int unsigned NUM_RAILS = srm_pkg::NUM_RAILS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rail_addr[7:0], write_byte[15:8],
                                        // rail_is_on[16], rail_good[17], zero pad
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // read_byte[7:0], polled_rail[10:8],
                                        // turn_on[11], turn_off[12],
                                        // keep_alive_hold[13], rail_led[14],
                                        // fault_led[15]
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned IDX_W = (NUM_RAILS > 1) ? $clog2(NUM_RAILS) : 1;
    localparam logic [2:0] LAST_RAIL = 3'(NUM_RAILS);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    // ---------------- configuration ----------------
    logic [2:0] keep_alive_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == srm_pkg::REG_KEEP_ALIVE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_alive_reg <= srm_pkg::KEEP_ALIVE_RESET;
        end else if (cfg_wr) begin
            keep_alive_reg <= pwdata[2:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == srm_pkg::REG_KEEP_ALIVE) begin
            prdata = {29'd0, keep_alive_reg};
        end
    end

    // ---------------- request fields ----------------
    logic [1:0] in_req;
    logic [7:0] in_addr;
    logic [7:0] in_wbyte;
    logic       in_on;
    logic       in_good;
    logic [7:0] addr_m1;
    logic       in_addr_ok;

    assign in_req     = s_tuser;
    assign in_addr    = s_tdata[7:0];
    assign in_wbyte   = s_tdata[15:8];
    assign in_on      = s_tdata[16];
    assign in_good    = s_tdata[17];
    assign addr_m1    = in_addr - 8'd1;
    assign in_addr_ok = (in_addr != 8'd0) && (in_addr <= 8'(NUM_RAILS));

    // ---------------- control registers ----------------
    state_t              state_reg;
    logic [2:0]          poll_ptr_reg;
    logic                fault_reg;
    logic                out_valid_reg;
    srm_pkg::result_t    out_reg;

    // latched item
    logic [1:0]          req_reg;
    logic                addr_ok_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                wbit_reg;
    logic                on_reg;
    logic                good_reg;
    logic [2:0]          rail_reg;

    logic                accept;
    logic [IDX_W-1:0]    rd_idx;
    logic [2:0]          poll_m1;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign poll_m1  = poll_ptr_reg - 3'd1;

    always_comb begin
        rd_idx = '0;
        if (in_req == srm_pkg::REQ_POLL) begin
            rd_idx = poll_m1[IDX_W-1:0];
        end else if (in_addr_ok) begin
            rd_idx = addr_m1[IDX_W-1:0];
        end
    end

    // ---------------- entry memory ----------------
    logic [2:0]           rail_mem [NUM_RAILS];
    logic [NUM_RAILS-1:0] valid_reg;
    logic [2:0]           rd_data_reg;
    logic                 rd_valid_reg;
    logic                 mem_we;
    logic [2:0]           wr_data;

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg  <= rail_mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
        end
        if (mem_we) begin
            rail_mem[idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // ---------------- modify ----------------
    logic [2:0]       entry;
    logic             en;
    logic             was;
    logic             fault_next;
    srm_pkg::result_t out_next;

    assign entry = rd_valid_reg ? rd_data_reg : srm_pkg::rail_reset(3'(idx_reg));
    assign en    = entry[srm_pkg::BIT_EN];
    assign was   = entry[srm_pkg::BIT_LAST];

    always_comb begin
        out_next   = '0;
        fault_next = fault_reg;
        mem_we     = 1'b0;
        wr_data    = entry;
        case (req_reg)
            srm_pkg::REQ_POLL: begin
                // write back only on the modify cycle of the item
                mem_we                     = (state_reg == ST_EXEC);
                wr_data[srm_pkg::BIT_PG]   = good_reg;
                wr_data[srm_pkg::BIT_LAST] = en;
                if (en != was) begin
                    if (en) begin
                        out_next.turn_on = 1'b1;
                    end else begin
                        out_next.turn_off = 1'b1;
                        // keep-alive rail comes straight back on a later visit
                        if (rail_reg == keep_alive_reg) begin
                            out_next.keep_alive_hold = 1'b1;
                            wr_data[srm_pkg::BIT_EN] = 1'b1;
                        end
                    end
                end
                // fault flag is sticky over one sweep, restarting at rail 1
                if (rail_reg == 3'd1) begin
                    fault_next = 1'b0;
                end
                if (on_reg && !good_reg) begin
                    fault_next = 1'b1;
                end
                out_next.rail_led    = on_reg && good_reg;
                out_next.polled_rail = rail_reg;
            end
            srm_pkg::REQ_READ: begin
                out_next.read_byte = addr_ok_reg ? {5'd0, entry} : srm_pkg::BYTE_BAD;
            end
            srm_pkg::REQ_WRITE: begin
                mem_we                   = addr_ok_reg && (state_reg == ST_EXEC);
                wr_data[srm_pkg::BIT_EN] = wbit_reg;
            end
            default: begin
                // unused code: no operation
            end
        endcase
        out_next.fault_led = fault_next;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            poll_ptr_reg  <= 3'd1;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg   <= ST_EXEC;
                        req_reg     <= in_req;
                        addr_ok_reg <= in_addr_ok;
                        idx_reg     <= rd_idx;
                        wbit_reg    <= in_wbyte[0];
                        on_reg      <= in_on;
                        good_reg    <= in_good;
                        rail_reg    <= poll_ptr_reg;
                        if (in_req == srm_pkg::REQ_POLL) begin
                            poll_ptr_reg <= (poll_ptr_reg >= LAST_RAIL) ? 3'd1
                                                                        : poll_ptr_reg + 3'd1;
                        end
                    end
                end
                ST_EXEC: begin
                    // output register is free here: accept waited for it
                    state_reg     <= ST_IDLE;
                    fault_reg     <= fault_next;
                    out_reg       <= out_next;
                    out_valid_reg <= 1'b1;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // ---------------- assertions ----------------
`include "supply_rail_monitor_regs_assert.svh"

    `SRM_ASSERT_NEXT(a_accept_exec, accept, state_reg == ST_EXEC && !s_tready)
    `SRM_ASSERT_SAME(a_pulse_excl, m_tvalid, !(out_reg.turn_on && out_reg.turn_off))
    `SRM_ASSERT_SAME(a_hold_off, m_tvalid && out_reg.keep_alive_hold, out_reg.turn_off)
    `SRM_ASSERT_SAME(a_poll_range, 1'b1, poll_ptr_reg != 3'd0 && poll_ptr_reg <= LAST_RAIL)

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Supply rail monitor register file testbench
// Drives poll ticks, bus reads and bus writes into the request channel. Each
// accepted item is run through a cycle-free model of the rail entries, and
// the result items are checked against it in order. The keep-alive register
// is rewritten over the APB port between phases, and stalls on both sides
// are applied at random.
// ----------------------------------------------------------------------------
`default_nettype none

localparam int unsigned RAILS = srm_pkg::NUM_RAILS_DEF;

// unused request code, treated by the block as no operation
localparam logic [1:0] REQ_NONE = 2'd3;

typedef struct {
    logic [1:0] req;
    logic [7:0] addr;
    logic [7:0] wbyte;
    logic       on;
    logic       good;
} rail_req_t;

// Rail entry model and the queue of results it predicts.
class rail_result_board;
    logic [2:0]       ctrl [1:RAILS];
    logic [2:0]       next_rail;
    logic             fault_flag;
    logic [2:0]       keep_alive;
    srm_pkg::result_t pending_results [$];
    int               errors;

    function new();
        for (int i = 1; i <= RAILS; i++) begin
            ctrl[i] = '0;
        end
        ctrl[4][srm_pkg::BIT_EN] = 1'b1;
        next_rail  = 3'd1;
        fault_flag = 1'b0;
        keep_alive = srm_pkg::KEEP_ALIVE_RESET;
        errors     = 0;
    endfunction

    function void set_keep_alive(input logic [2:0] val);
        keep_alive = val;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void note_request(input rail_req_t it);
        srm_pkg::result_t r;
        logic [2:0]       c;
        logic [2:0]       p;
        logic             en;
        logic             was;
        bit               addr_ok;
        r = '0;
        addr_ok = (it.addr >= 8'd1) && (it.addr <= 8'(RAILS));
        case (it.req)
            srm_pkg::REQ_POLL: begin
                p = next_rail;
                if (p < 3'd1 || p > 3'(RAILS)) begin
                    p = 3'd1;
                end
                c = ctrl[p];
                c[srm_pkg::BIT_PG] = it.good;
                en  = c[srm_pkg::BIT_EN];
                was = c[srm_pkg::BIT_LAST];
                c[srm_pkg::BIT_LAST] = en;
                if (en && !was) begin
                    r.turn_on = 1'b1;
                end else if (!en && was) begin
                    r.turn_off = 1'b1;
                    if (p == keep_alive) begin
                        r.keep_alive_hold = 1'b1;
                        c[srm_pkg::BIT_EN] = 1'b1;
                    end
                end
                ctrl[p] = c;
                if (p == 3'd1) begin
                    fault_flag = 1'b0;
                end
                if (it.on && !it.good) begin
                    fault_flag = 1'b1;
                end
                r.rail_led    = it.on && it.good;
                r.polled_rail = p;
                next_rail = (p >= 3'(RAILS)) ? 3'd1 : p + 3'd1;
            end
            srm_pkg::REQ_READ: begin
                r.read_byte = addr_ok ? {5'b0, ctrl[it.addr[2:0]]} : srm_pkg::BYTE_BAD;
            end
            srm_pkg::REQ_WRITE: begin
                if (addr_ok) begin
                    ctrl[it.addr[2:0]][srm_pkg::BIT_EN] = it.wbyte[0];
                end
            end
            default: begin
            end
        endcase
        r.fault_led = fault_flag;
        pending_results.push_back(r);
    endfunction

    task report(input string msg);
        errors++;
        if (errors <= 100) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    task check_result(input logic [15:0] word);
        srm_pkg::result_t got;
        srm_pkg::result_t want;
        got = word;
        if (pending_results.size() == 0) begin
            report($sformatf("result item %h with nothing outstanding", word));
        end else begin
            want = pending_results.pop_front();
            if (got.read_byte != want.read_byte)
                report($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
            if (got.polled_rail != want.polled_rail)
                report($sformatf("polled_rail %0d, want %0d",
                                 got.polled_rail, want.polled_rail));
            if (got.turn_on != want.turn_on)
                report($sformatf("turn_on %b, want %b", got.turn_on, want.turn_on));
            if (got.turn_off != want.turn_off)
                report($sformatf("turn_off %b, want %b", got.turn_off, want.turn_off));
            if (got.keep_alive_hold != want.keep_alive_hold)
                report($sformatf("keep_alive_hold %b, want %b",
                                 got.keep_alive_hold, want.keep_alive_hold));
            if (got.rail_led != want.rail_led)
                report($sformatf("rail_led %b, want %b", got.rail_led, want.rail_led));
            if (got.fault_led != want.fault_led)
                report($sformatf("fault_led %b, want %b", got.fault_led, want.fault_led));
        end
    endtask
endclass

module tb;

    localparam logic [2:0] KEEP_ALIVE_ADDR = {srm_pkg::REG_KEEP_ALIVE, 2'b00};
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         SEGMENTS        = 6;
    localparam int         SEGMENT_ITEMS   = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = srm_pkg::REQ_POLL;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire logic [31:0] prdata;
    wire logic   pready;

    // percentage of cycles in which each side holds off
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;

    rail_result_board book = new();

    supply_rail_monitor_regs i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic rail_req_t make_req(input logic [1:0] req, input logic [7:0] addr,
                                           input logic [7:0] wbyte, input logic on,
                                           input logic good);
        rail_req_t it;
        it.req   = req;
        it.addr  = addr;
        it.wbyte = wbyte;
        it.on    = on;
        it.good  = good;
        return it;
    endfunction

    // Half of the items are ticks, so that sweeps go round and enable changes get seen;
    // addresses sit near the rail range with the odd wild byte.
    function automatic rail_req_t random_req();
        rail_req_t it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)      it.req = srm_pkg::REQ_POLL;
        else if (pick < 72) it.req = srm_pkg::REQ_READ;
        else if (pick < 95) it.req = srm_pkg::REQ_WRITE;
        else                it.req = REQ_NONE;
        it.addr  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
        it.wbyte = 8'($urandom_range(255));
        it.on    = 1'($urandom_range(1));
        it.good  = ($urandom_range(3) != 0);
        return it;
    endfunction

    // Call just after a rising edge. Hold valid low through any gap, then
    // present the item until it is taken; valid stays high on return.
    task automatic send_item(input rail_req_t it);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {6'b0, it.good, it.on, it.wbyte, it.addr};
        do @(posedge aclk); while (!s_tready);
        book.note_request(it);
    endtask

    // Drop valid and wait for every outstanding result, then a short pause.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access cycle sees pready.
    task automatic write_keep_alive(input logic [2:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEEP_ALIVE_ADDR;
        pwdata  <= {29'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_keep_alive(val);
    endtask

    task automatic run_directed();
        // reads of every rail and of addresses that name none
        for (int a = 1; a <= RAILS; a++) begin
            send_item(make_req(srm_pkg::REQ_READ, 8'(a), 8'hFF, 1'b1, 1'b0));
        end
        send_item(make_req(srm_pkg::REQ_READ, 8'd0,   8'h00, 1'b0, 1'b1));
        send_item(make_req(srm_pkg::REQ_READ, 8'd6,   8'h00, 1'b0, 1'b0));
        send_item(make_req(srm_pkg::REQ_READ, 8'hFF,  8'hFF, 1'b1, 1'b1));
        // enable rail 1; writes to bad addresses and the spare code do nothing
        send_item(make_req(srm_pkg::REQ_WRITE, 8'd1,  8'h01, 1'b0, 1'b0));
        send_item(make_req(srm_pkg::REQ_WRITE, 8'd0,  8'hFF, 1'b1, 1'b1));
        send_item(make_req(srm_pkg::REQ_WRITE, 8'hFF, 8'hFF, 1'b1, 1'b1));
        send_item(make_req(REQ_NONE,           8'hFF, 8'hFF, 1'b1, 1'b1));
        // first sweep: rails 1 and 4 turn on, a fault is latched on rail 2
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b1, 1'b1));
        send_item(make_req(srm_pkg::REQ_POLL, 8'hFF, 8'hFF, 1'b1, 1'b0));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b1));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b1, 1'b1));
        // switch off the keep-alive rail; the second sweep clears the fault
        // at rail 1 and pulses turn_off with the hold request on rail 4
        send_item(make_req(srm_pkg::REQ_WRITE, 8'd4, 8'hFE, 1'b1, 1'b1));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b1, 1'b1));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b1, 1'b1));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b1, 1'b0));
        send_item(make_req(srm_pkg::REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b1));
        send_item(make_req(srm_pkg::REQ_READ, 8'd4, 8'h00, 1'b0, 1'b0));
    endtask

    // Receiver side: randomise ready, check results, and watch for a hang.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (aresetn && m_tvalid && m_tready) begin
            book.check_result(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("supply_rail_monitor_regs: mismatch");
            $finish;
        end
    end

    initial begin
        // keep-alive settings per phase: both ends of the rail range, then
        // values that name no rail, then back inside
        logic [2:0] ka_seq [SEGMENTS] = '{3'd1, 3'd5, 3'd0, 3'd7, 3'd3, 3'd4};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 28;
        recv_idle = 77;
        run_directed();
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // receiver sparse first, then sender sparse, then flat out
            if (seg < 2) begin
                send_idle = 28;
                recv_idle = 77;
            end else if (seg < 4) begin
                send_idle = 77;
                recv_idle = 28;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_keep_alive(ka_seq[seg]);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                send_item(random_req());
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("supply_rail_monitor_regs: match");
        end else begin
            $display("supply_rail_monitor_regs: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
